// ===== hdl/vbt_pkg.sv =====
// Package for the variometer beep tone generator.
// Holds the channel payload types, the configuration register map and the
// mapping constants. Used by every module of the block; depends on nothing.
package vbt_pkg;

    // Input and result payloads.
    typedef struct packed {
        logic signed [11:0] vertical_speed;
        logic        [31:0] time_ms;
    } vbt_in_t;

    typedef struct packed {
        logic        tone_on;
        logic [10:0] pitch_hz;
    } vbt_out_t;

    // Configuration register set.
    typedef struct packed {
        logic              enable;
        logic signed [9:0] dead_band_low;
        logic        [8:0] dead_band_high;
    } vbt_cfg_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 10;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_ENABLE  = 2'd0,
        REG_DB_LOW  = 2'd1,
        REG_DB_HIGH = 2'd2
    } vbt_reg_idx_t;

    localparam logic              ResetEnable = 1'b0;
    localparam logic signed [9:0] ResetDbLow  = -10'sd18;
    localparam logic        [8:0] ResetDbHigh = 9'd18;

    // Speed limit and mapping end points.
    localparam logic signed [11:0] SpeedLimitPos = 12'sd500;
    localparam logic signed [11:0] SpeedLimitNeg = -12'sd500;
    localparam logic         [9:0] SpeedLimit    = 10'd500;
    localparam logic        [10:0] PitchLow      = 11'd20;
    localparam logic        [10:0] PitchZero     = 11'd220;
    localparam logic         [7:0] DurLong       = 8'd200;

    // Reciprocals for the constant divisions: n/5 exact for n <= 1000,
    // n/25 for n <= 32000, n/50 for n <= 8500 (sink feeds n/5 up to 2000).
    localparam logic  [7:0] RecipDiv5   = 8'd205;
    localparam int          ShiftDiv5   = 10;
    localparam logic [15:0] RecipDiv25  = 16'd41944;
    localparam int          ShiftDiv25  = 20;
    localparam logic [12:0] RecipDiv50  = 13'd5243;
    localparam int          ShiftDiv50  = 18;

endpackage

// ===== hdl/vbt_cfg_regs.sv =====
// Configuration register file of the variometer beep tone generator.
// Plain write port, no read-back. Depends on vbt_pkg.
module vbt_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [vbt_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [vbt_pkg::CfgDataWidth-1:0]    cfg_wdata,
    output vbt_pkg::vbt_cfg_t                   cfg
);
    import vbt_pkg::*;

    vbt_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= ResetEnable;
            cfg_reg.dead_band_low  <= ResetDbLow;
            cfg_reg.dead_band_high <= ResetDbHigh;
        end else if (cfg_wr_en) begin
            case (vbt_reg_idx_t'(cfg_index))
                REG_ENABLE:  cfg_reg.enable         <= cfg_wdata[0];
                REG_DB_LOW:  cfg_reg.dead_band_low  <= cfg_wdata[9:0];
                REG_DB_HIGH: cfg_reg.dead_band_high <= cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/vbt_tone_map.sv =====
// Speed to pitch and beep phase duration mapping.
// Pure combinational logic: clamp, then linear maps with constant
// reciprocal multiplications. Depends on vbt_pkg.
module vbt_tone_map (
    input  logic signed [11:0] speed,
    output logic        [10:0] pitch_hz,
    output logic         [7:0] duration_ms
);
    import vbt_pkg::*;

    logic signed [9:0] v;
    logic        [9:0] sink_x;
    logic       [10:0] sink_n;
    logic       [18:0] sink_prod;
    logic        [8:0] climb_v;
    logic       [14:0] climb_n;
    logic       [30:0] climb_prod;
    logic       [13:0] dur_n;
    logic       [26:0] dur_prod;
    logic       [10:0] sink_pitch;
    logic       [10:0] climb_pitch;

    always_comb begin
        if (speed > SpeedLimitPos) begin
            v = 10'(SpeedLimitPos);
        end else if (speed < SpeedLimitNeg) begin
            v = 10'(SpeedLimitNeg);
        end else begin
            v = speed[9:0];
        end
    end

    // Sink: (v + 500) * 200 / 500 + 20, i.e. (v + 500) * 2 / 5 + 20.
    // The 10-bit wrap-around sum is exact because v is at least -500.
    assign sink_x     = 10'($unsigned(v) + SpeedLimit);
    assign sink_n     = {sink_x, 1'b0};
    assign sink_prod  = 19'(sink_n) * 19'(RecipDiv5);
    assign sink_pitch = 11'(sink_prod >> ShiftDiv5) + PitchLow;

    // Climb: v * 1280 / 500 + 220, i.e. v * 64 / 25 + 220.
    assign climb_v     = v[8:0];
    assign climb_n     = {climb_v, 6'b0};
    assign climb_prod  = 31'(climb_n) * 31'(RecipDiv25);
    assign climb_pitch = 11'(climb_prod >> ShiftDiv25) + PitchZero;

    // Duration: 200 - v * 170 / 500, i.e. 200 - v * 17 / 50.
    assign dur_n       = 14'(climb_v) * 14'd17;
    assign dur_prod    = 27'(dur_n) * 27'(RecipDiv50);
    assign duration_ms = DurLong - 8'(dur_prod >> ShiftDiv50);

    assign pitch_hz = v[9] || (v == 10'sd0) ? sink_pitch : climb_pitch;

endmodule

// ===== hdl/vario_beep_tone_generator.sv =====
// Top level of the variometer beep tone generator.
// Instantiates vbt_cfg_regs and vbt_tone_map; depends on vbt_pkg.
//
// One item is accepted per clock cycle when the result side keeps up. An
// accepted item is held in an input register, is evaluated by a single
// stage of clamp, constant-multiply and 32-bit time compare logic, and its
// result is loaded into the output register once that register is empty
// or being taken, and is offered from there. The beep phase state is
// updated in the same edge that loads the result, which keeps consecutive
// items strictly ordered. Configuration is written through a plain write
// port (index 0 enable, 1 dead band low, 2 dead band high) and must only
// change while no item is in flight.
module vario_beep_tone_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vbt_pkg::vbt_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vbt_pkg::vbt_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [vbt_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [vbt_pkg::CfgDataWidth-1:0]    cfg_wdata
);
    import vbt_pkg::*;

    vbt_cfg_t cfg;

    vbt_in_t  in_reg;
    logic     in_valid_reg;
    vbt_out_t out_reg;
    vbt_out_t out_next;
    logic     out_valid_reg;

    logic        silent_reg;
    logic        silent_next;
    logic [31:0] phase_start_reg;
    logic [31:0] phase_start_next;

    logic        advance;
    logic [10:0] pitch;
    logic  [7:0] duration;
    logic signed [12:0] speed_ext;
    logic        in_band;
    logic        active;
    logic        climb;
    logic [31:0] limit;
    logic        expired;
    logic        tone;

    vbt_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vbt_tone_map u_tone_map (
        .speed       (in_reg.vertical_speed),
        .pitch_hz    (pitch),
        .duration_ms (duration)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        speed_ext = {in_reg.vertical_speed[11], in_reg.vertical_speed};
        in_band   = (speed_ext >= 13'(cfg.dead_band_low)) &&
                    (speed_ext <= $signed({4'b0, cfg.dead_band_high}));
        active    = cfg.enable && !in_band;
        climb     = !in_reg.vertical_speed[11] && (|in_reg.vertical_speed);
        // The phase end wraps modulo 2^32 before the compare.
        limit     = phase_start_reg + 32'(duration);
        expired   = limit < in_reg.time_ms;

        silent_next      = silent_reg;
        phase_start_next = phase_start_reg;
        if (active) begin
            if (climb) begin
                if (expired) begin
                    silent_next      = !silent_reg;
                    phase_start_next = in_reg.time_ms;
                end
            end else begin
                silent_next = 1'b0;
            end
        end

        tone             = active && !silent_next;
        out_next.tone_on = tone;
        out_next.pitch_hz = tone ? pitch : 11'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            silent_reg      <= 1'b0;
            phase_start_reg <= 32'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg   <= 1'b1;
                silent_reg      <= silent_next;
                phase_start_reg <= phase_start_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
